// ----- hdl/md5_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round tables for the MD5 digest block.
// ----------------------------------------------------------------------------
package md5_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hEFCDAB89;
	localparam logic [31:0] INIT_C = 32'h98BADCFE;
	localparam logic [31:0] INIT_D = 32'h10325476;
	localparam logic [7:0]  PAD_BYTE = 8'h80;

	localparam logic REQ_ABSORB = 1'b0;
	localparam logic REQ_FINISH = 1'b1;

	typedef struct packed {
		logic       finish;
		logic [7:0] data;
	} md5_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} md5_state_t;

	function automatic logic [4:0] shift_amt(input logic [5:0] i);
		logic [4:0] r;
		unique case ({i[5:4], i[1:0]})
			4'b0000: r = 5'd7;  4'b0001: r = 5'd12; 4'b0010: r = 5'd17; 4'b0011: r = 5'd22;
			4'b0100: r = 5'd5;  4'b0101: r = 5'd9;  4'b0110: r = 5'd14; 4'b0111: r = 5'd20;
			4'b1000: r = 5'd4;  4'b1001: r = 5'd11; 4'b1010: r = 5'd16; 4'b1011: r = 5'd23;
			4'b1100: r = 5'd6;  4'b1101: r = 5'd10; 4'b1110: r = 5'd15; default: r = 5'd21;
		endcase
		return r;
	endfunction

	localparam logic [31:0] ROUND_K [64] = '{
		32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
		32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
		32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
		32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
		32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
		32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
		32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
		32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
		32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
		32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
		32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
		32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
		32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
		32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
		32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
		32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
	};

	function automatic logic [3:0] msg_index(input logic [5:0] i);
		logic [3:0] r;
		unique case (i[5:4])
			2'd0: r = i[3:0];
			2'd1: r = 4'((6'd5 * i) + 6'd1);
			2'd2: r = 4'((6'd3 * i) + 6'd5);
			default: r = 4'(6'd7 * i);
		endcase
		return r;
	endfunction

endpackage

// ----- hdl/md5_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_queue
// Small request queue between front end and compression engine.
// ----------------------------------------------------------------------------
module md5_queue
	import md5_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  md5_req_t in_req,
	output logic     out_valid,
	input  logic     out_ready,
	output md5_req_t out_req
);
	localparam int AW = $clog2(DEPTH);

	md5_req_t        mem_q [DEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [AW:0]     cnt_q;
	logic            push, pop;

	assign in_ready  = cnt_q != (AW+1)'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_req   = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

// ----- hdl/md5_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_engine
// Block buffer, padding and 64-round compression; emits the digest words.
// ----------------------------------------------------------------------------
module md5_engine
	import md5_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  md5_req_t    req,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [1:0]  word_index,
	output logic        last_word
);
	md5_state_t state_q, state_d;
	logic [31:0] buf_q [16];
	logic [5:0]  fill_q;
	logic [60:0] bytes_q;
	logic [31:0] h_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [5:0]  rnd_q;
	logic [5:0]  pad_q;
	logic        final_q;
	logic [1:0]  widx_q;

	logic [31:0] f, w, sum, rot;
	logic [3:0]  g;
	logic [4:0]  s;
	logic [63:0] bits;
	logic [7:0]  pad_byte;

	assign g = msg_index(rnd_q);
	assign s = shift_amt(rnd_q);
	assign w = buf_q[g];
	always_comb begin
		unique case (rnd_q[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (d_q & b_q) | (~d_q & c_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
	end
	assign sum  = a_q + f + ROUND_K[rnd_q] + w;
	assign rot  = (s == 5'd0) ? sum : ((sum << s) | (sum >> (6'd32 - {1'b0, s})));
	assign bits = {bytes_q, 3'b000};
	// length goes into the block whose padding started below byte 56
	always_comb begin
		if (pad_q >= 6'd56 && fill_q < 6'd56) pad_byte = bits[{pad_q[2:0], 3'b000} +: 8];
		else pad_byte = 8'h00;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req.finish) state_d = (fill_q == 6'd63) ? ST_LOAD : ST_PAD;
					else if (fill_q == 6'd63) state_d = ST_LOAD;
				end
			end
			ST_PAD:   if (pad_q == 6'd63) state_d = ST_LOAD;
			ST_LOAD:  state_d = ST_ROUND;
			ST_ROUND: if (rnd_q == 6'd63) state_d = ST_ADD;
			ST_ADD: begin
				if (!final_q) state_d = ST_IDLE;
				else if (pad_q == 6'd0) state_d = ST_PAD;
				else state_d = ST_EMIT;
			end
			ST_EMIT:  if (out_ready && widx_q == 2'd3) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready   = state_q == ST_IDLE;
		out_valid   = state_q == ST_EMIT;
		digest_word = h_q[widx_q];
		word_index  = widx_q;
		last_word   = widx_q == 2'd3;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid)
			buf_q[fill_q[5:2]][{fill_q[1:0], 3'b000} +: 8] <= req.finish ? PAD_BYTE : req.data;
		if (state_q == ST_PAD) buf_q[pad_q[5:2]][{pad_q[1:0], 3'b000} +: 8] <= pad_byte;
		if (state_q == ST_LOAD) begin
			a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
		end
		if (state_q == ST_ROUND) begin
			a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= b_q + rot;
		end
	end

	// final_q: padding of the last block in progress; pad_q == 0 after ADD
	// means the length still needs its own block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			bytes_q <= '0;
			rnd_q   <= '0;
			pad_q   <= '0;
			final_q <= 1'b0;
			widx_q  <= '0;
			h_q[0] <= INIT_A; h_q[1] <= INIT_B; h_q[2] <= INIT_C; h_q[3] <= INIT_D;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						if (req.finish) begin
							final_q <= 1'b1;
							pad_q   <= fill_q + 1'b1;
							if (fill_q == 6'd63) fill_q <= '0;
						end else begin
							fill_q  <= fill_q + 1'b1;
							bytes_q <= bytes_q + 1'b1;
						end
					end
				end
				ST_PAD: begin
					if (pad_q == 6'd63) begin
						pad_q <= (fill_q >= 6'd56) ? 6'd0 : 6'd1;
						if (fill_q >= 6'd56) fill_q <= '0;
					end else begin
						pad_q <= pad_q + 1'b1;
					end
				end
				ST_LOAD: rnd_q <= '0;
				ST_ROUND: rnd_q <= rnd_q + 1'b1;
				ST_ADD: begin
					h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
					if (!final_q) fill_q <= '0;
					widx_q <= '0;
				end
				ST_EMIT: begin
					if (out_ready) begin
						widx_q <= widx_q + 1'b1;
						if (widx_q == 2'd3) begin
							h_q[0] <= INIT_A; h_q[1] <= INIT_B;
							h_q[2] <= INIT_C; h_q[3] <= INIT_D;
							fill_q <= '0; bytes_q <= '0; final_q <= 1'b0; pad_q <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end
endmodule

// ----- hdl/md5_message_digest_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_message_digest_top
// MD5 digest over a byte stream, four digest words out per message.
// ----------------------------------------------------------------------------
// Input channel (valid/ready): req_type 0 absorbs data_byte, 1 finishes the
// message. A request queue decouples the input from the engine.
// Absorbing takes bytes only while the engine is idle; every 64th byte runs the
// compression, one round per cycle through a single round unit.
// Finish writes the padding one byte per cycle, compresses
// one or two blocks, then offers four transfers on the output channel:
// digest_word with word_index 0..3, last_word set on the fourth.
// A stalled receiver holds the engine in its output state; the queue keeps
// taking requests until it fills. Reset restores the initial chain words,
// clears the byte count and empties the queue.
// ----------------------------------------------------------------------------
module md5_message_digest_top
	import md5_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [1:0]  word_index,
	output logic        last_word
);
	md5_req_t in_req, q_req;
	logic     q_valid, q_ready;

	assign in_req.finish = req_type == REQ_FINISH;
	assign in_req.data   = data_byte;

	md5_queue #(.DEPTH(DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
		.out_valid(q_valid), .out_ready(q_ready), .out_req(q_req)
	);

	md5_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.req_valid(q_valid), .req_ready(q_ready), .req(q_req),
		.out_valid(out_valid), .out_ready(out_ready),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);
endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 digest block testbench
// Streams messages byte by byte through the input channel, finishes each one
// and checks the four digest words against a behavioral MD5 predictor. Both
// channels idle at random; known digests check the predictor's word A.
// ----------------------------------------------------------------------------
module testbench;
	import md5_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        req_type;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] digest_word;
	logic [1:0]  word_index;
	logic        last_word;

	md5_message_digest_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .data_byte(data_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);

	typedef struct {
		logic [31:0] word;
		logic [1:0]  idx;
		logic        last;
	} digest_out_t;

	typedef struct {
		logic        kind;
		logic [7:0]  val;
		logic [31:0] known_a;
		bit          has_known;
	} stim_row_t;

	digest_out_t digest_q[$];
	logic [7:0]  blk_bytes[64];
	logic [31:0] chain[4];
	logic [60:0] byte_total;
	logic [6:0]  fill;
	int          fail_count;
	bit          calm;

	localparam logic [5:0] ROT_TBL [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
		4, 11, 16, 23, 6, 10, 15, 21};

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [31:0] rot_left(logic [31:0] x, int k);
		return (x << k) | (x >> (32 - k));
	endfunction

	task automatic md5_compress();
		logic [31:0] w[16];
		logic [31:0] a, b, c, d, f, t;
		int g;
		for (int i = 0; i < 16; i++)
			w[i] = {blk_bytes[4*i+3], blk_bytes[4*i+2], blk_bytes[4*i+1], blk_bytes[4*i]};
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
		for (int i = 0; i < 64; i++) begin
			if (i < 16) begin
				f = (b & c) | (~b & d); g = i;
			end else if (i < 32) begin
				f = (d & b) | (~d & c); g = (5*i + 1) % 16;
			end else if (i < 48) begin
				f = b ^ c ^ d; g = (3*i + 5) % 16;
			end else begin
				f = c ^ (b | ~d); g = (7*i) % 16;
			end
			t = d; d = c; c = b;
			b = b + rot_left(a + f + ROUND_K[i] + w[g], ROT_TBL[(i/16)*4 + i%4]);
			a = t;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
		fill = 7'd0;
	endtask

	task automatic md5_restart();
		chain[0] = INIT_A; chain[1] = INIT_B; chain[2] = INIT_C; chain[3] = INIT_D;
		byte_total = '0;
		fill = 7'd0;
	endtask

	task automatic md5_predict(logic kind, logic [7:0] val);
		logic [63:0] bits;
		digest_out_t e;
		if (kind == REQ_ABSORB) begin
			blk_bytes[fill[5:0]] = val;
			fill++;
			byte_total++;
			if (fill == 64) md5_compress();
			return;
		end
		blk_bytes[fill[5:0]] = PAD_BYTE;
		fill++;
		if (fill > 56) begin
			for (int i = fill; i < 64; i++) blk_bytes[i] = 8'h00;
			md5_compress();
		end
		for (int i = fill; i < 56; i++) blk_bytes[i] = 8'h00;
		bits = {byte_total, 3'b000};
		for (int i = 0; i < 8; i++) blk_bytes[56+i] = bits[8*i +: 8];
		md5_compress();
		for (int i = 0; i < 4; i++) begin
			e.word = chain[i]; e.idx = i[1:0]; e.last = (i == 3);
			digest_q.push_back(e);
		end
		md5_restart();
	endtask

	task automatic send_req(logic kind, logic [7:0] val);
		while (!calm && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		req_type  <= kind;
		data_byte <= val;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		md5_predict(kind, val);
	endtask

	always @(posedge clk) begin
		if (arst_n) out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 32);
	end

	always @(posedge clk) begin
		digest_out_t e;
		if (arst_n && out_valid && out_ready) begin
			if (digest_q.size() == 0) begin
				$display("%0t: unexpected transfer word=%h idx=%0d", $time,
					digest_word, word_index);
				fail_count++;
			end else begin
				e = digest_q.pop_front();
				if (digest_word !== e.word || word_index !== e.idx || last_word !== e.last) begin
					$display("%0t: mismatch exp word=%h idx=%0d last=%b act word=%h idx=%0d last=%b",
						$time, e.word, e.idx, e.last, digest_word, word_index, last_word);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		stim_row_t rows[$];
		stim_row_t r;
		int n, cnt;
		in_valid = 1'b0; req_type = REQ_ABSORB; data_byte = 8'h00; out_ready = 1'b0;
		arst_n = 1'b0; fail_count = 0; calm = 1'b0;
		md5_restart();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message, then "abc", then three more bytes; digest word A is known for the first two
		r = '{REQ_FINISH, 8'h00, 32'hD98C1DD4, 1}; rows.push_back(r);
		r = '{REQ_ABSORB, 8'h61, 0, 0}; rows.push_back(r);
		r = '{REQ_ABSORB, 8'h62, 0, 0}; rows.push_back(r);
		r = '{REQ_ABSORB, 8'h63, 0, 0}; rows.push_back(r);
		r = '{REQ_FINISH, 8'hFF, 32'h98500190, 1}; rows.push_back(r);
		r = '{REQ_ABSORB, 8'h00, 0, 0}; rows.push_back(r);
		r = '{REQ_ABSORB, 8'hFF, 0, 0}; rows.push_back(r);
		r = '{REQ_ABSORB, 8'h80, 0, 0}; rows.push_back(r);
		r = '{REQ_FINISH, 8'h00, 0, 0}; rows.push_back(r);
		foreach (rows[i]) begin
			if (rows[i].has_known && rows[i].kind == REQ_FINISH) begin
				send_req(rows[i].kind, rows[i].val);
				if (digest_q[digest_q.size()-4].word !== rows[i].known_a) begin
					$display("%0t: known digest exp=%h act=%h", $time, rows[i].known_a,
						digest_q[digest_q.size()-4].word);
					fail_count++;
				end
			end else
				send_req(rows[i].kind, rows[i].val);
		end
		cnt = rows.size();

		// finish one byte short of a block boundary, no idling
		calm = 1'b1;
		for (int i = 0; i < 63; i++) send_req(REQ_ABSORB, 8'($urandom));
		send_req(REQ_FINISH, 8'($urandom));
		cnt += 64;
		calm = 1'b0;

		// random messages, short ones and ones near the length boundary
		while (cnt < 120) begin
			n = ($urandom_range(3) == 0) ? 52 + $urandom_range(8) : $urandom_range(8);
			if (n > 119 - cnt) n = 119 - cnt;
			for (int i = 0; i < n; i++) begin
				send_req(REQ_ABSORB, 8'($urandom));
				cnt++;
			end
			send_req(REQ_FINISH, 8'($urandom));
			cnt++;
		end
		in_valid <= 1'b0;

		n = 0;
		while (digest_q.size() != 0 && n < 200000) begin
			@(posedge clk);
			n++;
		end
		repeat (200) @(posedge clk);
		if (fail_count == 0 && digest_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
